[rtl/core/asedit_pkg.sv]
// Shared types and constants for the approximate substring edit distance block.
// Used by asedit_regs, asedit_cell and the top level; depends on nothing else.
package asedit_pkg;

  localparam int CHAR_W = 8;
  localparam int DIST_W = 5;
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 5;
  localparam int PAT_BITS = 128;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_PAT_LO  = 2'd0;
  localparam logic [1:0] REG_PAT_HI  = 2'd1;
  localparam logic [1:0] REG_PAT_LEN = 2'd2;
  localparam logic [1:0] REG_LIMIT   = 2'd3;

  // What one cell hands to its right neighbor.
  typedef struct packed {
    logic              fire;
    logic [DIST_W-1:0] col;
    logic [DIST_W-1:0] diag;
  } link_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [CFG_DW-1:0] pat_lo;
    logic [CFG_DW-1:0] pat_hi;
    logic [DIST_W-1:0] len;
    logic [DIST_W-1:0] limit;
    logic              len_wr;
    logic [DIST_W-1:0] len_new;
  } cfg_t;

endpackage

[rtl/core/asedit_regs.sv]
// APB-style configuration registers: pattern bytes, pattern length and limit.
// Depends on asedit_pkg.
module asedit_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [asedit_pkg::CFG_AW-1:0] paddr,
  input  logic [asedit_pkg::CFG_DW-1:0] pwdata,
  output logic [asedit_pkg::CFG_DW-1:0] prdata,
  output logic                          pready,
  output asedit_pkg::cfg_t              cfg_o
);
  import asedit_pkg::*;

  logic [CFG_DW-1:0] pat_lo_q;
  logic [CFG_DW-1:0] pat_hi_q;
  logic [DIST_W-1:0] len_q;
  logic [DIST_W-1:0] limit_q;
  logic [1:0]        idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_AW-1:CFG_AW-2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= '0;
      limit_q  <= '0;
    end else if (wr) begin
      case (idx)
        REG_PAT_LO:  pat_lo_q <= pwdata;
        REG_PAT_HI:  pat_hi_q <= pwdata;
        REG_PAT_LEN: len_q    <= pwdata[DIST_W-1:0];
        REG_LIMIT:   limit_q  <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PAT_LO:  prdata = pat_lo_q;
      REG_PAT_HI:  prdata = pat_hi_q;
      REG_PAT_LEN: prdata = {{(CFG_DW-DIST_W){1'b0}}, len_q};
      REG_LIMIT:   prdata = {{(CFG_DW-DIST_W){1'b0}}, limit_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.pat_lo  = pat_lo_q;
  assign cfg_o.pat_hi  = pat_hi_q;
  assign cfg_o.len     = len_q;
  assign cfg_o.limit   = limit_q;
  assign cfg_o.len_wr  = wr && (idx == REG_PAT_LEN);
  assign cfg_o.len_new = pwdata[DIST_W-1:0];

endmodule

[rtl/core/asedit_cell.sv]
// One pattern cell: holds one entry of the previous column and computes its new entry.
// Depends on asedit_pkg.
module asedit_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  logic                          en_i,
  input  logic [asedit_pkg::CHAR_W-1:0] char_i,
  input  logic [asedit_pkg::CHAR_W-1:0] pat_char_i,
  input  logic [asedit_pkg::DIST_W-1:0] init_i,
  input  asedit_pkg::link_t             left_i,
  output asedit_pkg::link_t             right_o
);
  import asedit_pkg::*;

  logic              loaded_q;
  logic              fire_q;
  logic [DIST_W-1:0] prev_q;
  logic [DIST_W-1:0] old_q;
  logic [DIST_W-1:0] prev_eff;
  logic [DIST_W-1:0] from_up;
  logic [DIST_W-1:0] from_left;
  logic [DIST_W-1:0] from_diag;
  logic [DIST_W-1:0] best2;
  logic [DIST_W-1:0] col_d;
  logic              fire;

  // Until the cell is first written after a restart, its entry reads as its row index.
  assign prev_eff = loaded_q ? prev_q : init_i;
  assign fire     = left_i.fire && en_i;

  always_comb begin
    from_up   = left_i.col + DIST_W'(1);
    from_left = prev_eff + DIST_W'(1);
    from_diag = left_i.diag + ((pat_char_i == char_i) ? DIST_W'(0) : DIST_W'(1));
    best2     = (from_up < from_left) ? from_up : from_left;
    col_d     = (best2 < from_diag) ? best2 : from_diag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      fire_q   <= 1'b0;
    end else begin
      fire_q <= fire;
      if (restart_i) begin
        loaded_q <= 1'b0;
      end else if (fire) begin
        loaded_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      prev_q <= col_d;
      old_q  <= prev_eff;
    end
  end

  assign right_o.fire = fire_q;
  assign right_o.col  = prev_eff;
  assign right_o.diag = old_q;

endmodule

[rtl/core/approx_substring_edit_distance.sv]
// Top level of the approximate substring edit distance block (Sellers' recurrence).
// Depends on asedit_pkg, asedit_regs and asedit_cell.
//
// The block streams a text one byte per transfer and reports, on the transfer marked
// end_of_text, the smallest edit distance between the configured pattern and any
// substring of the text, plus whether that distance is within distance_limit. The
// dynamic programming column lives in a row of PATTERN_MAX cells; cell k holds row k.
// A character enters cell 1 the cycle after it is taken and a fire token walks one
// cell per cycle to cell m (the pattern length, clipped to PATTERN_MAX), each cell
// handing its new and old entries to the next. The input stalls while a character
// is in the row; an end_of_text transfer then loads the result register, and an
// empty item or a zero-length pattern skips the row. The result register lets a new
// text start while the previous result waits to be taken. Writing pattern_length
// restarts the current text. Configuration is only written while the block is
// idle: the user must keep to this, as the block does not enforce it. Registers
// sit at byte addresses 0, 8, 16 and 24 (pattern bytes 0-7 and 8-15, length, limit).
module approx_substring_edit_distance #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [asedit_pkg::CFG_AW-1:0] paddr,
  input  logic [asedit_pkg::CFG_DW-1:0] pwdata,
  output logic [asedit_pkg::CFG_DW-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [asedit_pkg::CHAR_W-1:0] text_char_i,
  input  logic                          end_of_text_i,
  input  logic                          empty_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [asedit_pkg::DIST_W-1:0] best_distance_o,
  output logic                          within_limit_o
);
  import asedit_pkg::*;

  localparam int LEN_IDX_W = $clog2(PATTERN_MAX + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COMP = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  cfg_t                  cfg;
  link_t                 link [0:PATTERN_MAX];
  link_t                 tap;
  logic [PATTERN_MAX:0]  fire_vec;
  logic [PAT_BITS-1:0]   pat_all;
  logic [LEN_IDX_W-1:0]  m;
  logic [1:0]            state_q;
  logic                  go_q;
  logic [CHAR_W-1:0]     char_q;
  logic                  last_q;
  logic [DIST_W-1:0]     rm_q;
  logic                  out_valid_q;
  logic [DIST_W-1:0]     best_q;
  logic                  within_q;
  logic                  accept;
  logic                  fin_load;
  logic                  restart;

  function automatic logic [LEN_IDX_W-1:0] clip_len(logic [DIST_W-1:0] v);
    if (v > PATTERN_MAX) begin
      return LEN_IDX_W'(PATTERN_MAX);
    end
    return LEN_IDX_W'(v);
  endfunction

  asedit_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign m       = clip_len(cfg.len);
  assign pat_all = {cfg.pat_hi, cfg.pat_lo};

  // Row zero of every column is zero, so the source of the chain hands zeros.
  assign link[0].fire = go_q;
  assign link[0].col  = '0;
  assign link[0].diag = '0;

  for (genvar k = 1; k <= PATTERN_MAX; k++) begin : g_cell
    asedit_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .restart_i  (restart),
      .en_i       (LEN_IDX_W'(k) <= m),
      .char_i     (char_q),
      .pat_char_i (pat_all[CHAR_W*(k-1) +: CHAR_W]),
      .init_i     (DIST_W'(k)),
      .left_i     (link[k-1]),
      .right_o    (link[k])
    );
  end

  for (genvar k = 0; k <= PATTERN_MAX; k++) begin : g_fire
    assign fire_vec[k] = link[k].fire;
  end

  // The last row of the column arrives from cell m.
  assign tap = link[m];

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign fin_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign restart    = fin_load || cfg.len_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
      rm_q        <= '0;
    end else begin
      go_q <= accept && !empty_item_i && (m != '0);
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (!empty_item_i && (m != '0)) begin
              state_q <= ST_COMP;
            end else if (end_of_text_i) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_COMP: begin
          if (tap.fire) begin
            if (tap.col < rm_q) begin
              rm_q <= tap.col;
            end
            state_q <= last_q ? ST_FIN : ST_IDLE;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            out_valid_q <= 1'b1;
            rm_q        <= DIST_W'(m);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // A new pattern length restarts the text; its running-minimum reload wins over the updates above.
      if (cfg.len_wr) begin
        rm_q <= DIST_W'(clip_len(cfg.len_new));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= text_char_i;
      last_q <= end_of_text_i;
    end
    if (fin_load) begin
      best_q   <= rm_q;
      within_q <= (rm_q <= cfg.limit);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign best_distance_o = best_q;
  assign within_limit_o  = within_q;

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(fire_vec))
    else $error("more than one fire token in the cell row");

  a_min_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rm_q <= DIST_W'(m))
    else $error("running minimum above the pattern length");

  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> last_q)
    else $error("result pending for an item not marked last");

  a_restart_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_load && !cfg.len_wr) |=> (rm_q == DIST_W'(m)))
    else $error("running minimum not reloaded after a result");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (best_distance_o <= PATTERN_MAX))
    else $error("reported distance out of range");
`endif

endmodule

[sim/approx_substring_edit_distance_tb.sv]
// Self-checking testbench for approx_substring_edit_distance: streams texts against
// configured patterns and compares each reported distance with an in-bench predictor.
// Depends on asedit_pkg and the approx_substring_edit_distance RTL.
`timescale 1ns / 100ps

module approx_substring_edit_distance_tb;
  import asedit_pkg::*;

  localparam int PATTERN_MAX = 16;
  // A margin that covers a character's pass through the whole cell row and an end
  // mark's result load, before the block is considered quiet.
  localparam int SETTLE_CYCLES = 2 * PATTERN_MAX + 8;
  localparam int ITEM_TARGET = 1250;

  // One text transfer as the sender presents it.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              is_empty;
  } text_item_t;

  // One distance report as the block should deliver it.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              hit;
  } score_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CHAR_W-1:0] text_char_i = '0;
  logic              end_of_text_i = 1'b0;
  logic              empty_item_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DIST_W-1:0] best_distance_o;
  logic              within_limit_o;

  approx_substring_edit_distance #(
    .PATTERN_MAX(PATTERN_MAX)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_char_i    (text_char_i),
    .end_of_text_i  (end_of_text_i),
    .empty_item_i   (empty_item_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .best_distance_o(best_distance_o),
    .within_limit_o (within_limit_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Items waiting to be sent and distance reports waiting to arrive.
  text_item_t pending_text[$];
  score_t     expected_scores[$];
  int         random_items = 0;
  int         mismatch_count = 0;

  // Shadow copy of the configuration registers and of the scoring column.
  logic [CFG_DW-1:0] pat_lo_q = '0;
  logic [CFG_DW-1:0] pat_hi_q = '0;
  logic [DIST_W-1:0] pat_len_q = '0;
  logic [DIST_W-1:0] limit_q = '0;
  int                dp_column[0:PATTERN_MAX];
  int                running_best;

  // Pattern lengths above PATTERN_MAX saturate.
  function automatic int effective_length();
    return (pat_len_q > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_q);
  endfunction

  function automatic logic [7:0] pattern_char(int k);
    logic [2*CFG_DW-1:0] bits;
    bits = {pat_hi_q, pat_lo_q};
    return bits[8*k +: 8];
  endfunction

  // A fresh text: column entry k is k (k deletions), best is the pattern length.
  function automatic void restart_scoring();
    for (int k = 0; k <= PATTERN_MAX; k++) dp_column[k] = k;
    running_best = effective_length();
  endfunction

  // Advances the column by one text character (Sellers' recurrence, top row zero) and
  // queues the expected report when the transfer closes a text. An empty item that
  // does not close a text leaves everything as it is.
  function automatic void consume_text_item(text_item_t it);
    int fresh[0:PATTERN_MAX];
    int m;
    int cost;
    score_t report;
    m = effective_length();
    if (!it.is_empty) begin
      fresh[0] = 0;
      for (int k = 1; k <= m; k++) begin
        cost = (pattern_char(k - 1) == it.ch) ? 0 : 1;
        fresh[k] = (fresh[k-1] + 1 < dp_column[k] + 1) ? fresh[k-1] + 1 : dp_column[k] + 1;
        if (dp_column[k-1] + cost < fresh[k]) fresh[k] = dp_column[k-1] + cost;
      end
      if (fresh[m] < running_best) running_best = fresh[m];
      for (int k = 0; k <= m; k++) dp_column[k] = fresh[k];
    end
    if (it.last) begin
      report = '{distance: DIST_W'(running_best),
                 hit: (running_best <= int'(limit_q))};
      expected_scores = {expected_scores, report};
      restart_scoring();
    end
  endfunction

  // Picks how many cycles a side holds back. Most holds are zero or short, a few are
  // long, and now and then a calm stretch with no holds at all begins.
  function automatic int pick_idle_span(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(40, 200);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sender. An item is taken at an edge with valid high and stall low; the predictor
  // runs on it right there, so it always sees the configuration in force.
  int         send_gap = 0;
  int         send_calm = 0;
  text_item_t next_item;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        consume_text_item('{ch: text_char_i, last: end_of_text_i, is_empty: empty_item_i});
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_text.size() > 0) begin
          next_item = pending_text.pop_front();
          text_char_i <= next_item.ch;
          end_of_text_i <= next_item.last;
          empty_item_i <= next_item.is_empty;
          in_valid_i <= 1'b1;
          send_gap = pick_idle_span(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver. Checks every result transfer against the oldest expected report and
  // stalls the output at random.
  int     recv_hold = 0;
  int     recv_calm = 0;
  score_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_scores.size() == 0) begin
          $error("result transfer with no report expected: best_distance %0d",
                 best_distance_o);
          mismatch_count++;
        end else begin
          want = expected_scores.pop_front();
          if (best_distance_o !== want.distance) begin
            $error("best_distance: expected %0d, actual %0d", want.distance,
                   best_distance_o);
            mismatch_count++;
          end
          if (within_limit_o !== want.hit) begin
            $error("within_limit: expected %0d, actual %0d", want.hit, within_limit_o);
            mismatch_count++;
          end
        end
      end
      if (recv_hold == 0) recv_hold = pick_idle_span(recv_calm);
      out_stall_i <= (recv_hold > 0);
      if (recv_hold > 0) recv_hold--;
    end
  end

  task automatic add_text_item(logic [7:0] ch, logic last, logic is_empty);
    text_item_t item;
    item = '{ch: ch, last: last, is_empty: is_empty};
    pending_text = {pending_text, item};
    if (last || !is_empty) random_items++;
  endtask

  // Two-phase register write; the register takes the value at the access edge.
  task automatic write_register(logic [1:0] idx, logic [CFG_DW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PAT_LO: pat_lo_q = value;
      REG_PAT_HI: pat_hi_q = value;
      REG_PAT_LEN: begin
        // A length write throws away the text in progress.
        pat_len_q = value[DIST_W-1:0];
        restart_scoring();
      end
      REG_LIMIT: limit_q = value[DIST_W-1:0];
      default: ;
    endcase
  endtask

  // Holds the sender back until every report has arrived and the block is quiet.
  task automatic wait_until_idle();
    while (pending_text.size() != 0 || in_valid_i || expected_scores.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One text: mostly characters drawn from the pattern with random edits in between,
  // so that small distances occur, plus stray empty items and now and then an empty
  // item as the closing transfer. Some texts are empty.
  task automatic queue_random_text(int base, bit wide);
    int  len;
    int  walk;
    int  m;
    int  r;
    bit  close_with_empty;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 5) len = 0;
    else if (r < 80) len = $urandom_range(1, 24);
    else if (r < 96) len = $urandom_range(25, 60);
    else len = $urandom_range(61, 120);
    if (len == 0) begin
      add_text_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      return;
    end
    close_with_empty = ($urandom_range(0, 9) == 0);
    walk = $urandom_range(0, 15);
    m = effective_length();
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) add_text_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      r = $urandom_range(0, 99);
      if (r < 45 && m > 0) begin
        c = pattern_char(walk % m);
        walk += ($urandom_range(0, 9) == 0) ? 2 : 1;
      end else if (wide) begin
        c = 8'($urandom_range(0, 255));
      end else begin
        c = 8'(base + $urandom_range(0, 3));
      end
      add_text_item(c, (i == len - 1) && !close_with_empty, 1'b0);
    end
    if (close_with_empty) add_text_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  initial begin : stimulus
    int                  phase;
    int                  phase_end;
    int                  base;
    int                  len;
    int                  r;
    bit                  wide;
    logic [2*CFG_DW-1:0] pat_bits;
    logic [CFG_DW-1:0]   word;

    restart_scoring();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero pattern length straight after reset: every distance is zero, an empty
    // text included.
    add_text_item(8'hFF, 1'b1, 1'b0);
    add_text_item(8'h00, 1'b1, 1'b1);
    wait_until_idle();

    // Pattern 00 FF 02 03, limit 1. Extreme characters, a stray empty item, a text
    // one deletion off, an empty text that reports the pattern length, an exact match.
    write_register(REG_PAT_LO, 64'h0706_0504_0302_FF00);
    write_register(REG_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(REG_PAT_LEN, 64'd4);
    write_register(REG_LIMIT, 64'd1);
    add_text_item(8'h00, 1'b0, 1'b0);
    add_text_item(8'hA5, 1'b0, 1'b1);
    add_text_item(8'hFF, 1'b0, 1'b0);
    add_text_item(8'h02, 1'b1, 1'b0);
    add_text_item(8'h00, 1'b1, 1'b1);
    add_text_item(8'h55, 1'b0, 1'b0);
    add_text_item(8'h00, 1'b0, 1'b0);
    add_text_item(8'hFF, 1'b0, 1'b0);
    add_text_item(8'h02, 1'b0, 1'b0);
    add_text_item(8'h03, 1'b1, 1'b0);

    // Pattern characters change halfway through a text; the later columns use them.
    add_text_item(8'h00, 1'b0, 1'b0);
    add_text_item(8'hFF, 1'b0, 1'b0);
    wait_until_idle();
    write_register(REG_PAT_LO, 64'h0706_0504_3322_FF00);
    add_text_item(8'h22, 1'b0, 1'b0);
    add_text_item(8'h33, 1'b1, 1'b0);

    // A length write in the middle of a text restarts it; 31 saturates to the
    // maximum, and the largest limit is tried too.
    add_text_item(8'h01, 1'b0, 1'b0);
    add_text_item(8'h02, 1'b0, 1'b0);
    wait_until_idle();
    write_register(REG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(REG_LIMIT, 64'd31);
    add_text_item(8'h00, 1'b1, 1'b0);
    add_text_item(8'h00, 1'b1, 1'b1);

    // Random phases, each under its own configuration. The first four pin the length
    // to its extremes, and the first two pin the limit to its extremes as well.
    random_items = 0;
    phase = 0;
    while (random_items < ITEM_TARGET) begin
      wait_until_idle();
      base = $urandom_range(0, 252);
      wide = ($urandom_range(0, 4) == 0);
      for (int b = 0; b < 16; b++) begin
        pat_bits[8*b +: 8] = wide ? 8'($urandom_range(0, 255)) : 8'(base + $urandom_range(0, 3));
      end
      if (phase < 4 || $urandom_range(0, 2) != 0) write_register(REG_PAT_LO, pat_bits[63:0]);
      if (phase < 4 || $urandom_range(0, 2) != 0) write_register(REG_PAT_HI, pat_bits[127:64]);
      r = $urandom_range(0, 99);
      case (phase)
        0: len = PATTERN_MAX;
        1: len = 1;
        2: len = 31;
        3: len = 0;
        default: len = (r < 10) ? $urandom_range(17, 31) :
                       (r < 20) ? PATTERN_MAX : $urandom_range(1, PATTERN_MAX);
      endcase
      // Upper data bits are random; only the low five reach the register.
      word = {$urandom, $urandom};
      word[DIST_W-1:0] = DIST_W'(len);
      write_register(REG_PAT_LEN, word);
      if (phase < 4 || $urandom_range(0, 4) != 0) begin
        word = {$urandom, $urandom};
        case (phase)
          0: word[DIST_W-1:0] = '0;
          1: word[DIST_W-1:0] = 5'd31;
          default: word[DIST_W-1:0] = ($urandom_range(0, 9) == 0) ?
                     DIST_W'($urandom_range(0, 31)) :
                     DIST_W'($urandom_range(0, effective_length() + 1));
        endcase
        write_register(REG_LIMIT, word);
      end
      phase_end = random_items + $urandom_range(80, 220);
      if (phase_end > ITEM_TARGET) phase_end = ITEM_TARGET;
      while (random_items < phase_end) queue_random_text(base, wide);
      // Sometimes the phase stops inside a text so the next writes land mid-text.
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) add_text_item(8'(base + $urandom_range(0, 3)), 1'b0, 1'b0);
      end
      phase++;
    end

    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("approx_substring_edit_distance verification clean");
    end else begin
      $display("approx_substring_edit_distance verification failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every item waiting out the longest sender gap,
  // the longest output stall and the full systolic latency.
  initial begin : watchdog
    #5_000_000;
    $display("approx_substring_edit_distance verification failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/asedit_pkg.sv
rtl/core/asedit_regs.sv
rtl/core/asedit_cell.sv
rtl/core/approx_substring_edit_distance.sv
sim/approx_substring_edit_distance_tb.sv
